### rtl/dll_pkg.sv
// Shared types for the doubly linked list engine: command codes, sequencer
// states and the input and result beat structs. No dependencies.
package dll_pkg;

  typedef enum logic [3:0] {
    ACT_CLEAR     = 4'd0,
    ACT_INS_FIRST = 4'd1,
    ACT_INS_LAST  = 4'd2,
    ACT_ACT_FIRST = 4'd3,
    ACT_ACT_LAST  = 4'd4,
    ACT_DEL_FIRST = 4'd5,
    ACT_DEL_LAST  = 4'd6,
    ACT_POST_DEL  = 4'd7,
    ACT_PRE_DEL   = 4'd8,
    ACT_POST_INS  = 4'd9,
    ACT_PRE_INS   = 4'd10,
    ACT_UPDATE    = 4'd11,
    ACT_SUCC      = 4'd12,
    ACT_PRED      = 4'd13
  } dll_action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_WR,
    S_VAL
  } dll_state_t;

  typedef struct packed {
    logic [3:0]         action;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic               nonempty;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
    logic               active_valid;
    logic signed [31:0] active_value;
    logic               full_error;
    logic [4:0]         entry_count;
  } out_beat_t;

endpackage

### rtl/doubly_linked_list_engine_top.sv
// Doubly linked list engine: node pool in three synchronous memories
// (value, next link, previous link) plus a used-slot map in flip-flops.
// Depends on dll_pkg.
//
// Usage: drive in_data and raise start; the command beat is taken at the
// edge where start is high and busy is low. busy stays high while the
// command runs. One result beat follows per command on out_data, marked by
// out_valid for exactly one cycle; the receiver cannot stall it.
// Commands that read no link go from execution straight to the value
// reload; those that read one link hop (delete at an end of a list of two
// or more, a step that moves, a delete after or before the active node that
// removes an end) pass through S_RD1 first. A delete after or before the
// active node that splices around the removed node passes through S_RD1
// and S_RD2, and insert after or before it through S_RD1 and S_WR. One
// command is in flight at a time. The link memories have registered reads
// (one read per dependent hop), and the value memory's single read port
// reloads the first, last and active values in turn. After reset the list
// is empty, no node is active and the block is idle. New nodes always take
// the lowest-numbered free slot.
module doubly_linked_list_engine_top #(
  parameter int POOL_DEPTH  = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dll_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output dll_pkg::out_beat_t out_data
);

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);

  function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [31:0] v);
    logic [VALUE_WIDTH-1:0] r;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      r[i] = v[(i < 32) ? i : 31];
    end
    return r;
  endfunction

  function automatic logic [31:0] to_report(input logic [VALUE_WIDTH-1:0] s);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = s[(i < VALUE_WIDTH) ? i : VALUE_WIDTH - 1];
    end
    return r;
  endfunction

  // Pool memories.
  logic [VALUE_WIDTH-1:0] val_mem [POOL_DEPTH];
  logic [AW-1:0]          nxt_mem [POOL_DEPTH];
  logic [AW-1:0]          prv_mem [POOL_DEPTH];

  logic                   val_we, nxt_we, prv_we;
  logic [AW-1:0]          val_wa, nxt_wa, prv_wa, val_ra, lnk_ra;
  logic [VALUE_WIDTH-1:0] val_wd, val_rd_r;
  logic [AW-1:0]          nxt_wd, prv_wd, nxt_rd_r, prv_rd_r;

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    val_rd_r <= val_mem[val_ra];
    nxt_rd_r <= nxt_mem[lnk_ra];
    prv_rd_r <= prv_mem[lnk_ra];
  end

  dll_pkg::dll_state_t  state_r, state_nxt;
  dll_pkg::dll_action_t act_r, act_nxt;
  logic [VALUE_WIDTH-1:0] vin_r, vin_nxt;
  logic [AW-1:0]   head_r, head_nxt, tail_r, tail_nxt, aix_r, aix_nxt;
  logic [AW-1:0]   n_r, n_nxt, o_r, o_nxt, lk_r, lk_nxt, free_idx;
  logic            aflag_r, aflag_nxt, err_r, err_nxt, full_r, full_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [POOL_DEPTH-1:0] used_r, used_nxt;
  logic [1:0]      vcnt_r, vcnt_nxt;
  logic [VALUE_WIDTH-1:0] hv_r, hv_nxt, tv_r, tv_nxt;
  logic            out_valid_r, out_valid_nxt;
  dll_pkg::out_beat_t out_r, out_nxt;
  logic [31:0]     cnt32;

  always_comb begin
    free_idx = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dll_pkg::S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      aix_r       <= '0;
      aflag_r     <= 1'b0;
      cnt_r       <= '0;
      used_r      <= '0;
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      aix_r       <= aix_nxt;
      aflag_r     <= aflag_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      vcnt_r      <= vcnt_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    vin_r  <= vin_nxt;
    n_r    <= n_nxt;
    o_r    <= o_nxt;
    lk_r   <= lk_nxt;
    full_r <= full_nxt;
    hv_r   <= hv_nxt;
    tv_r   <= tv_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    vin_nxt   = vin_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    aix_nxt   = aix_r;
    aflag_nxt = aflag_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    n_nxt     = n_r;
    o_nxt     = o_r;
    lk_nxt    = lk_r;
    full_nxt  = full_r;
    err_nxt   = err_r;
    vcnt_nxt  = vcnt_r;
    hv_nxt    = hv_r;
    tv_nxt    = tv_r;
    out_nxt   = out_r;
    out_valid_nxt = 1'b0;
    val_we = 1'b0; val_wa = n_r;    val_wd = vin_r;
    nxt_we = 1'b0; nxt_wa = n_r;    nxt_wd = head_r;
    prv_we = 1'b0; prv_wa = n_r;    prv_wd = tail_r;
    lnk_ra = aix_r;
    val_ra = head_r;
    cnt32  = '0;

    case (state_r)
      dll_pkg::S_IDLE: begin
        if (start) begin
          act_nxt   = dll_pkg::dll_action_t'(in_data.action);
          vin_nxt   = to_store(in_data.value);
          n_nxt     = free_idx;
          full_nxt  = (cnt_r == CW'(POOL_DEPTH));
          err_nxt   = 1'b0;
          state_nxt = dll_pkg::S_EXEC;
        end
      end

      dll_pkg::S_EXEC: begin
        state_nxt = dll_pkg::S_VAL;
        vcnt_nxt  = '0;
        case (act_r)
          dll_pkg::ACT_CLEAR: begin
            used_nxt  = '0;
            cnt_nxt   = '0;
            head_nxt  = '0;
            tail_nxt  = '0;
            aix_nxt   = '0;
            aflag_nxt = 1'b0;
          end
          dll_pkg::ACT_INS_FIRST, dll_pkg::ACT_INS_LAST: begin
            if (full_r) begin
              err_nxt = 1'b1;
            end else begin
              used_nxt[n_r] = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              val_we  = 1'b1;
              if (cnt_r == '0) begin
                head_nxt = n_r;
                tail_nxt = n_r;
              end else if (act_r == dll_pkg::ACT_INS_FIRST) begin
                nxt_we = 1'b1; nxt_wa = n_r;    nxt_wd = head_r;
                prv_we = 1'b1; prv_wa = head_r; prv_wd = n_r;
                head_nxt = n_r;
              end else begin
                prv_we = 1'b1; prv_wa = n_r;    prv_wd = tail_r;
                nxt_we = 1'b1; nxt_wa = tail_r; nxt_wd = n_r;
                tail_nxt = n_r;
              end
            end
          end
          dll_pkg::ACT_ACT_FIRST, dll_pkg::ACT_ACT_LAST: begin
            if (cnt_r == '0) begin
              aflag_nxt = 1'b0;
            end else begin
              aix_nxt   = (act_r == dll_pkg::ACT_ACT_FIRST) ? head_r : tail_r;
              aflag_nxt = 1'b1;
            end
          end
          dll_pkg::ACT_DEL_FIRST, dll_pkg::ACT_DEL_LAST: begin
            if (cnt_r != '0) begin
              o_nxt = (act_r == dll_pkg::ACT_DEL_FIRST) ? head_r : tail_r;
              if (aflag_r && aix_r == o_nxt) begin
                aflag_nxt = 1'b0;
              end
              used_nxt[o_nxt] = 1'b0;
              cnt_nxt = cnt_r - 1'b1;
              if (cnt_r == CW'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else begin
                lnk_ra    = o_nxt;
                state_nxt = dll_pkg::S_RD1;
              end
            end
          end
          dll_pkg::ACT_POST_DEL: begin
            if (aflag_r && aix_r != tail_r) begin
              state_nxt = dll_pkg::S_RD1;
            end
          end
          dll_pkg::ACT_PRE_DEL: begin
            if (aflag_r && aix_r != head_r) begin
              state_nxt = dll_pkg::S_RD1;
            end
          end
          dll_pkg::ACT_POST_INS, dll_pkg::ACT_PRE_INS: begin
            if (aflag_r) begin
              if (full_r) begin
                err_nxt = 1'b1;
              end else begin
                used_nxt[n_r] = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
                val_we    = 1'b1;
                state_nxt = dll_pkg::S_RD1;
              end
            end
          end
          dll_pkg::ACT_UPDATE: begin
            if (aflag_r) begin
              val_we = 1'b1;
              val_wa = aix_r;
            end
          end
          dll_pkg::ACT_SUCC: begin
            if (aflag_r) begin
              if (aix_r == tail_r) begin
                aflag_nxt = 1'b0;
              end else begin
                state_nxt = dll_pkg::S_RD1;
              end
            end
          end
          dll_pkg::ACT_PRED: begin
            if (aflag_r) begin
              if (aix_r == head_r) begin
                aflag_nxt = 1'b0;
              end else begin
                state_nxt = dll_pkg::S_RD1;
              end
            end
          end
          default: ;
        endcase
      end

      // Link data of the first hop is on nxt_rd_r / prv_rd_r here.
      dll_pkg::S_RD1: begin
        state_nxt = dll_pkg::S_VAL;
        case (act_r)
          dll_pkg::ACT_DEL_FIRST: head_nxt = nxt_rd_r;
          dll_pkg::ACT_DEL_LAST:  tail_nxt = prv_rd_r;
          dll_pkg::ACT_POST_DEL, dll_pkg::ACT_PRE_DEL: begin
            o_nxt = (act_r == dll_pkg::ACT_POST_DEL) ? nxt_rd_r : prv_rd_r;
            used_nxt[o_nxt] = 1'b0;
            cnt_nxt = cnt_r - 1'b1;
            if (act_r == dll_pkg::ACT_POST_DEL && o_nxt == tail_r) begin
              tail_nxt = aix_r;
            end else if (act_r == dll_pkg::ACT_PRE_DEL && o_nxt == head_r) begin
              head_nxt = aix_r;
            end else begin
              lnk_ra    = o_nxt;
              state_nxt = dll_pkg::S_RD2;
            end
          end
          dll_pkg::ACT_POST_INS: begin
            lk_nxt = nxt_rd_r;
            nxt_we = 1'b1; nxt_wa = n_r; nxt_wd = nxt_rd_r;
            prv_we = 1'b1; prv_wa = n_r; prv_wd = aix_r;
            if (aix_r == tail_r) begin
              tail_nxt = n_r;
            end
            state_nxt = dll_pkg::S_WR;
          end
          dll_pkg::ACT_PRE_INS: begin
            lk_nxt = prv_rd_r;
            prv_we = 1'b1; prv_wa = n_r; prv_wd = prv_rd_r;
            nxt_we = 1'b1; nxt_wa = n_r; nxt_wd = aix_r;
            if (aix_r == head_r) begin
              head_nxt = n_r;
            end
            state_nxt = dll_pkg::S_WR;
          end
          dll_pkg::ACT_SUCC: aix_nxt = nxt_rd_r;
          dll_pkg::ACT_PRED: aix_nxt = prv_rd_r;
          default: ;
        endcase
      end

      // Second hop of a delete next to the active node: splice around o.
      dll_pkg::S_RD2: begin
        state_nxt = dll_pkg::S_VAL;
        if (act_r == dll_pkg::ACT_POST_DEL) begin
          nxt_we = 1'b1; nxt_wa = aix_r;    nxt_wd = nxt_rd_r;
          prv_we = 1'b1; prv_wa = nxt_rd_r; prv_wd = aix_r;
        end else begin
          prv_we = 1'b1; prv_wa = aix_r;    prv_wd = prv_rd_r;
          nxt_we = 1'b1; nxt_wa = prv_rd_r; nxt_wd = aix_r;
        end
      end

      // The new node became an end exactly when the active node was that end.
      dll_pkg::S_WR: begin
        state_nxt = dll_pkg::S_VAL;
        if (act_r == dll_pkg::ACT_POST_INS) begin
          nxt_we = 1'b1; nxt_wa = aix_r; nxt_wd = n_r;
          if (tail_r != n_r) begin
            prv_we = 1'b1; prv_wa = lk_r; prv_wd = n_r;
          end
        end else begin
          prv_we = 1'b1; prv_wa = aix_r; prv_wd = n_r;
          if (head_r != n_r) begin
            nxt_we = 1'b1; nxt_wa = lk_r; nxt_wd = n_r;
          end
        end
      end

      // Reload head, tail and active values through the single read port.
      dll_pkg::S_VAL: begin
        vcnt_nxt = vcnt_r + 1'b1;
        case (vcnt_r)
          2'd0: val_ra = head_r;
          2'd1: begin
            val_ra = tail_r;
            hv_nxt = val_rd_r;
          end
          2'd2: begin
            val_ra = aix_r;
            tv_nxt = val_rd_r;
          end
          default: begin
            cnt32 = 32'(cnt_r);
            out_nxt.nonempty     = (cnt_r != '0);
            out_nxt.first_value  = (cnt_r != '0) ? to_report(hv_r) : '0;
            out_nxt.last_value   = (cnt_r != '0) ? to_report(tv_r) : '0;
            out_nxt.active_valid = aflag_r;
            out_nxt.active_value = aflag_r ? to_report(val_rd_r) : '0;
            out_nxt.full_error   = err_r;
            out_nxt.entry_count  = cnt32[4:0];
            out_valid_nxt = 1'b1;
            state_nxt     = dll_pkg::S_IDLE;
          end
        endcase
      end

      default: state_nxt = dll_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != dll_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(POOL_DEPTH))
    else $error("node count exceeds pool depth");

  a_out_after_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == dll_pkg::S_VAL))
    else $error("result beat without value reload");

  a_err_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.full_error) |->
      (act_r == dll_pkg::ACT_INS_FIRST || act_r == dll_pkg::ACT_INS_LAST ||
       act_r == dll_pkg::ACT_POST_INS || act_r == dll_pkg::ACT_PRE_INS))
    else $error("full error on a command that does not insert");

  a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    aflag_r |-> (cnt_r != '0))
    else $error("active node set on an empty list");

endmodule

### test/tb.sv
// Self-checking testbench for doubly_linked_list_engine_top: a directed command
// table followed by weighted random commands, checked against a behavioral list.
// Depends on dll_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 16;
  localparam int N_RANDOM = 1630;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dll_pkg::in_beat_t in_data = '0;
  logic out_valid;
  dll_pkg::out_beat_t out_data;

  always #4 clk = ~clk;

  doubly_linked_list_engine_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Behavioral copy of the node pool.
  logic signed [31:0] pool_val [DEPTH];
  logic [3:0] pool_next [DEPTH];
  logic [3:0] pool_prev [DEPTH];
  logic [DEPTH-1:0] pool_used;
  logic [3:0] head_q, tail_q, cur_q;
  logic cur_on;
  int unsigned list_len;

  dll_pkg::out_beat_t status_q[$];
  int errors = 0;
  int beats_seen = 0;
  int full_hits = 0;
  longint cycles = 0;

  function automatic logic [3:0] grab_slot(logic signed [31:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = DEPTH - 1; i >= 0; i--) if (!pool_used[i]) s = 4'(i);
    pool_used[s] = 1'b1;
    pool_val[s] = v;
    list_len++;
    return s;
  endfunction

  function automatic void drop_slot(logic [3:0] s);
    pool_used[s] = 1'b0;
    if (list_len > 0) list_len--;
  endfunction

  function automatic dll_pkg::out_beat_t apply_command(dll_pkg::in_beat_t b);
    dll_pkg::out_beat_t r;
    logic err, full;
    logic [3:0] n, o;
    err = 1'b0;
    full = list_len >= DEPTH;
    case (b.action)
      dll_pkg::ACT_CLEAR: begin
        pool_used = '0; list_len = 0; head_q = '0; tail_q = '0; cur_q = '0; cur_on = 0;
      end
      dll_pkg::ACT_INS_FIRST, dll_pkg::ACT_INS_LAST: begin
        if (full) err = 1'b1;
        else begin
          n = grab_slot(b.value);
          if (list_len == 1) begin
            head_q = n; tail_q = n;
          end else if (b.action == dll_pkg::ACT_INS_FIRST) begin
            pool_next[n] = head_q; pool_prev[head_q] = n; head_q = n;
          end else begin
            pool_prev[n] = tail_q; pool_next[tail_q] = n; tail_q = n;
          end
        end
      end
      dll_pkg::ACT_ACT_FIRST, dll_pkg::ACT_ACT_LAST: begin
        if (list_len == 0) cur_on = 1'b0;
        else begin
          cur_q = (b.action == dll_pkg::ACT_ACT_FIRST) ? head_q : tail_q;
          cur_on = 1'b1;
        end
      end
      dll_pkg::ACT_DEL_FIRST, dll_pkg::ACT_DEL_LAST: begin
        if (list_len != 0) begin
          o = (b.action == dll_pkg::ACT_DEL_FIRST) ? head_q : tail_q;
          if (cur_on && cur_q == o) cur_on = 1'b0;
          if (list_len == 1) begin
            head_q = '0; tail_q = '0;
          end else if (b.action == dll_pkg::ACT_DEL_FIRST) head_q = pool_next[o];
          else tail_q = pool_prev[o];
          drop_slot(o);
        end
      end
      dll_pkg::ACT_POST_DEL: begin
        if (cur_on && cur_q != tail_q) begin
          o = pool_next[cur_q];
          if (o == tail_q) tail_q = cur_q;
          else begin
            pool_next[cur_q] = pool_next[o]; pool_prev[pool_next[o]] = cur_q;
          end
          drop_slot(o);
        end
      end
      dll_pkg::ACT_PRE_DEL: begin
        if (cur_on && cur_q != head_q) begin
          o = pool_prev[cur_q];
          if (o == head_q) head_q = cur_q;
          else begin
            pool_prev[cur_q] = pool_prev[o]; pool_next[pool_prev[o]] = cur_q;
          end
          drop_slot(o);
        end
      end
      dll_pkg::ACT_POST_INS: begin
        if (cur_on && full) err = 1'b1;
        else if (cur_on) begin
          n = grab_slot(b.value);
          pool_prev[n] = cur_q; pool_next[n] = pool_next[cur_q];
          if (cur_q == tail_q) tail_q = n;
          else pool_prev[pool_next[cur_q]] = n;
          pool_next[cur_q] = n;
        end
      end
      dll_pkg::ACT_PRE_INS: begin
        if (cur_on && full) err = 1'b1;
        else if (cur_on) begin
          n = grab_slot(b.value);
          pool_next[n] = cur_q; pool_prev[n] = pool_prev[cur_q];
          if (cur_q == head_q) head_q = n;
          else pool_next[pool_prev[cur_q]] = n;
          pool_prev[cur_q] = n;
        end
      end
      dll_pkg::ACT_UPDATE: if (cur_on) pool_val[cur_q] = b.value;
      dll_pkg::ACT_SUCC: begin
        if (cur_on) begin
          if (cur_q == tail_q) cur_on = 1'b0;
          else cur_q = pool_next[cur_q];
        end
      end
      dll_pkg::ACT_PRED: begin
        if (cur_on) begin
          if (cur_q == head_q) cur_on = 1'b0;
          else cur_q = pool_prev[cur_q];
        end
      end
      default: ;
    endcase
    r.nonempty = list_len > 0;
    r.first_value = (list_len > 0) ? pool_val[head_q] : '0;
    r.last_value = (list_len > 0) ? pool_val[tail_q] : '0;
    r.active_valid = cur_on;
    r.active_value = cur_on ? pool_val[cur_q] : '0;
    r.full_error = err;
    r.entry_count = list_len[4:0];
    return r;
  endfunction

  // Sends one command beat; the typed expectation is compared with the
  // predictor's so that the hand-written rows are checked twice. start is
  // left high so that the next beat can follow; the caller drops it for gaps.
  task automatic send_command(dll_pkg::in_beat_t b, bit has_fixed,
                              dll_pkg::out_beat_t fixed);
    dll_pkg::out_beat_t p;
    start <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = apply_command(b);
    if (p.full_error) full_hits++;
    if (has_fixed && p !== fixed) begin
      $display("%0t typed row mismatch: expected %h actual %h", $time, fixed, p);
      errors++;
    end
    status_q.push_back(p);
  endtask

  // Result checking: the receiver cannot stall, so every strobe is a beat.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      beats_seen++;
      if (status_q.size() == 0) begin
        $display("%0t unexpected result beat: actual %h", $time, out_data);
        errors++;
      end else begin
        dll_pkg::out_beat_t e;
        e = status_q.pop_front();
        if (out_data.nonempty !== e.nonempty || out_data.first_value !== e.first_value ||
            out_data.last_value !== e.last_value ||
            out_data.active_valid !== e.active_valid ||
            out_data.active_value !== e.active_value ||
            out_data.full_error !== e.full_error ||
            out_data.entry_count !== e.entry_count) begin
          $display("%0t result mismatch: expected %h actual %h", $time, e, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic dll_pkg::out_beat_t mk_status(logic ne, logic signed [31:0] f,
                                                   logic signed [31:0] l, logic av,
                                                   logic signed [31:0] a, logic fe,
                                                   logic [4:0] c);
    dll_pkg::out_beat_t r;
    r = '{ne, f, l, av, a, fe, c};
    return r;
  endfunction

  typedef struct {
    dll_pkg::in_beat_t cmd;
    bit has_fixed;
    dll_pkg::out_beat_t fixed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(dll_pkg::dll_action_t a, logic signed [31:0] v,
                                  bit hf, dll_pkg::out_beat_t f);
    dir_row_t r;
    r.cmd.action = a;
    r.cmd.value = v;
    r.has_fixed = hf;
    r.fixed = f;
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      default: return $urandom;
    endcase
  endfunction

  // Commands are weighted toward inserts; while the list holds fewer than 12
  // entries some of them insert at an end, once it is longer all insert beside the cursor.
  function automatic dll_pkg::dll_action_t pick_action();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return dll_pkg::ACT_CLEAR;
    if (list_len < 12 && r < 35) return dll_pkg::dll_action_t'($urandom_range(1, 2));
    if (r < 45) return dll_pkg::dll_action_t'($urandom_range(9, 10));
    if (r < 55) return dll_pkg::dll_action_t'($urandom_range(3, 4));
    if (r < 72) return dll_pkg::dll_action_t'($urandom_range(12, 13));
    if (r < 88) return dll_pkg::dll_action_t'($urandom_range(5, 8));
    if (r < 97) return dll_pkg::ACT_UPDATE;
    return dll_pkg::dll_action_t'($urandom_range(14, 15));
  endfunction

  initial begin
    dll_pkg::in_beat_t b;
    dll_pkg::out_beat_t none;
    int burst;
    none = '0;
    pool_used = '0;
    list_len = 0; head_q = '0; tail_q = '0; cur_q = '0; cur_on = 0;
    for (int i = 0; i < DEPTH; i++) begin
      pool_val[i] = 0; pool_next[i] = '0; pool_prev[i] = '0;
    end

    // Empty-list cases first, then extremes, the cursor at both ends and a
    // full pool refusing an insert.
    add_row(dll_pkg::ACT_DEL_FIRST, 0, 1, mk_status(0, 0, 0, 0, 0, 0, 0));
    add_row(dll_pkg::ACT_ACT_LAST, 0, 1, mk_status(0, 0, 0, 0, 0, 0, 0));
    add_row(dll_pkg::ACT_POST_INS, 5, 1, mk_status(0, 0, 0, 0, 0, 0, 0));
    add_row(dll_pkg::ACT_INS_FIRST, 32'sh8000_0000, 1,
            mk_status(1, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 1));
    add_row(dll_pkg::ACT_INS_LAST, 32'sh7fff_ffff, 1,
            mk_status(1, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 2));
    add_row(dll_pkg::ACT_ACT_FIRST, 0, 0, none);
    add_row(dll_pkg::ACT_PRE_DEL, 0, 0, none);
    add_row(dll_pkg::ACT_POST_INS, -1, 0, none);
    add_row(dll_pkg::ACT_PRE_INS, 32'sh5555_aaaa, 0, none);
    add_row(dll_pkg::ACT_SUCC, 0, 0, none);
    add_row(dll_pkg::ACT_UPDATE, 32'shaaaa_5555, 0, none);
    add_row(dll_pkg::ACT_PRED, 0, 0, none);
    add_row(dll_pkg::ACT_POST_DEL, 0, 0, none);
    add_row(dll_pkg::ACT_PRE_DEL, 0, 0, none);
    add_row(dll_pkg::ACT_ACT_LAST, 0, 0, none);
    add_row(dll_pkg::ACT_SUCC, 0, 0, none);
    add_row(dll_pkg::dll_action_t'(4'd14), 0, 0, none);
    add_row(dll_pkg::dll_action_t'(4'd15), -1, 0, none);
    add_row(dll_pkg::ACT_DEL_LAST, 0, 0, none);
    add_row(dll_pkg::ACT_CLEAR, 0, 1, mk_status(0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < DEPTH; i++) add_row(dll_pkg::ACT_INS_LAST, i, 0, none);
    add_row(dll_pkg::ACT_INS_FIRST, 99, 1, mk_status(1, 0, 15, 0, 0, 1, 16));
    add_row(dll_pkg::ACT_ACT_FIRST, 0, 0, none);
    add_row(dll_pkg::ACT_PRE_INS, 7, 1, mk_status(1, 0, 15, 1, 0, 1, 16));
    add_row(dll_pkg::ACT_POST_DEL, 0, 0, none);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_command(dir_rows[i].cmd, dir_rows[i].has_fixed, dir_rows[i].fixed);
      if ($urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end

    burst = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      b.action = pick_action();
      b.value = rand_value();
      send_command(b, 0, none);
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 1)) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end else begin
        burst--;
      end
    end
    start <= 1'b0;

    while (status_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Ran %0d commands, checked %0d result beats, %0d refused inserts.",
             dir_rows.size() + N_RANDOM, beats_seen, full_hits);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
